// File: src/fpdac_pkg.sv
// Shared constants, types and step functions for the fuzzy PD angle controller.
`timescale 1ns / 1ps
`default_nettype none
package fpdac_pkg;

  localparam int FRAC_BITS = 8;

  localparam int SPAN_W = 7;
  localparam int STEP_W = 6;
  localparam int MEM_W = 17;
  localparam int Q_W = 31;
  localparam int KQ_W = 50;
  localparam int T_W = KQ_W - 32;
  localparam int AREA_W = 19;
  localparam int COMB_W = 22;
  localparam int CMAG_W = COMB_W - 1;
  localparam int PROD_W = CMAG_W + STEP_W;

  localparam logic [MEM_W-1:0] MEM_ONE = MEM_W'(65536);
  localparam logic [17:0] K_Q16 = 18'd193858;

  // output quotient holds 2^(FRAC_BITS+1) * |angle|; wide enough to reach both caps
  localparam int QB = (FRAC_BITS + 10 > 18) ? FRAC_BITS + 10 : 18;
  localparam int OD_SH = QB - FRAC_BITS - 1;

  localparam int FZ_BITS = 16;
  localparam int FZ_PER = 4;
  localparam int FZ_ST = FZ_BITS / FZ_PER;
  localparam int OD_PER = 3;
  localparam int OD_ST = (QB + OD_PER - 1) / OD_PER;

  localparam int S_RULE = FZ_ST + 1;
  localparam int S_Q = S_RULE + 1;
  localparam int S_K = S_Q + 1;
  localparam int S_AREA = S_K + 1;
  localparam int S_SEL = S_AREA + 1;
  localparam int S_MUL = S_SEL + 1;
  localparam int S_INIT = S_MUL + 1;
  localparam int S_OUT = S_INIT + OD_ST + 1;
  localparam int NST = S_OUT + 1;

  localparam logic [1:0] CASE_ZERO = 2'd0;
  localparam logic [1:0] CASE_NEG = 2'd1;
  localparam logic [1:0] CASE_POS = 2'd2;
  localparam logic [1:0] CASE_UNKNOWN = 2'd3;

  localparam logic [1:0] REG_ERROR_SPAN = 2'd0;
  localparam logic [1:0] REG_DELTA_SPAN = 2'd1;
  localparam logic [1:0] REG_OUTPUT_STEP = 2'd2;

  typedef struct packed {
    logic neg;
    logic full;
    logic nil;
    logic [SPAN_W-1:0] rem;
    logic [FZ_BITS-1:0] quo;
    logic [FZ_BITS-1:0] nb;
  } fz_t;

  typedef struct packed {
    logic neg;
    logic [1:0] cs;
    logic ovf;
    logic [AREA_W-1:0] den;
    logic [AREA_W-1:0] rem;
    logic [QB-1:0] quo;
    logic [QB-1:0] nb;
  } od_t;

  function automatic fz_t fz_init(input logic [15:0] x, input logic [SPAN_W-1:0] span);
    logic [15:0] mag;
    fz_t y;
    mag = x[15] ? 16'(~x + 16'd1) : x;
    y.neg = x[15];
    y.nil = (span == '0) && (mag == '0);
    y.full = (span == '0) ? (mag != '0)
                          : ({8'd0, mag} >= ({17'd0, span} << FRAC_BITS));
    y.rem = SPAN_W'(mag >> FRAC_BITS);
    y.quo = '0;
    y.nb = mag << (FZ_BITS - FRAC_BITS);
    return y;
  endfunction

  function automatic fz_t fz_step(input fz_t x, input logic [SPAN_W-1:0] span);
    logic [SPAN_W:0] r2;
    fz_t y;
    y = x;
    r2 = {x.rem, x.nb[FZ_BITS-1]};
    y.nb = {x.nb[FZ_BITS-2:0], 1'b0};
    if (r2 >= {1'b0, span}) begin
      y.rem = SPAN_W'(r2 - {1'b0, span});
      y.quo = {x.quo[FZ_BITS-2:0], 1'b1};
    end else begin
      y.rem = r2[SPAN_W-1:0];
      y.quo = {x.quo[FZ_BITS-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic fz_t fz_stage(input fz_t x, input logic [SPAN_W-1:0] span);
    fz_t y;
    y = x;
    for (int i = 0; i < FZ_PER; i++) begin
      y = fz_step(y, span);
    end
    return y;
  endfunction

  function automatic od_t od_step(input od_t x);
    logic [AREA_W:0] r2;
    od_t y;
    y = x;
    r2 = {x.rem, x.nb[QB-1]};
    y.nb = {x.nb[QB-2:0], 1'b0};
    if (r2 >= {1'b0, x.den}) begin
      y.rem = AREA_W'(r2 - {1'b0, x.den});
      y.quo = {x.quo[QB-2:0], 1'b1};
    end else begin
      y.rem = r2[AREA_W-1:0];
      y.quo = {x.quo[QB-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic od_t od_stage(input od_t x, input int first);
    od_t y;
    y = x;
    for (int i = 0; i < OD_PER; i++) begin
      if (first + i < QB) begin
        y = od_step(y);
      end
    end
    return y;
  endfunction

  function automatic logic [MEM_W-1:0] mmin(input logic [MEM_W-1:0] a,
                                            input logic [MEM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [MEM_W-1:0] mmax(input logic [MEM_W-1:0] a,
                                            input logic [MEM_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// File: src/fuzzy_pd_angle_controller_core.sv
// Fuzzy PD angle controller: pipelined fuzzify, rule, area and defuzzify datapath.
`timescale 1ns / 1ps
`default_nettype none
// Takes one error word per cycle while sample_stall is low and returns one result
// word per input, in order; there is no state between words. The pipeline holds
// two 16-step membership dividers (4 steps per stage), two multiplier stages for
// the areas and an 18-step output divider (3 steps per stage). The pipeline keeps
// moving into empty stages while the output word waits.
// Configuration registers are sampled live and must only be written while idle.
module fuzzy_pd_angle_controller_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [fpdac_pkg::SPAN_W-1:0] cfg_data,
  input  wire logic sample_valid,
  output logic sample_stall,
  input  wire logic signed [15:0] position_error,
  input  wire logic signed [15:0] error_change,
  output logic result_valid,
  input  wire logic result_stall,
  output logic signed [15:0] angle_change_fine,
  output logic signed [7:0] angle_change_rounded,
  output logic [1:0] dominant_case
);
  import fpdac_pkg::*;

  logic [SPAN_W-1:0] error_span;
  logic [SPAN_W-1:0] delta_span;
  logic [STEP_W-1:0] output_step;

  logic [NST-1:0] v;
  logic [NST:0] rdy;

  fz_t fz_e [0:FZ_ST];
  fz_t fz_d [0:FZ_ST];
  logic [MEM_W-1:0] rule_r [0:2];
  logic [MEM_W-1:0] q_r [0:2];
  logic [Q_W-1:0] q_v [0:2];
  logic [MEM_W-1:0] k_r [0:2];
  logic [KQ_W-1:0] k_v [0:2];
  logic [AREA_W-1:0] area [0:2];
  logic sel_neg;
  logic [1:0] sel_cs;
  logic [CMAG_W-1:0] sel_mag;
  logic [AREA_W-1:0] sel_den;
  logic mul_neg;
  logic [1:0] mul_cs;
  logic [PROD_W-1:0] mul_p;
  logic [AREA_W-1:0] mul_den;
  od_t od [0:OD_ST];

  logic [MEM_W-1:0] me [0:2];
  logic [MEM_W-1:0] md [0:2];
  logic [MEM_W-1:0] m_e, m_d;
  logic signed [COMB_W-1:0] sp, sz, sn, comb;
  logic [1:0] cs_next;
  logic [AREA_W-1:0] den_next;
  logic [QB:0] fm, fm_cap;
  logic [QB-1:0] rm, rm_cap;
  logic [15:0] fm_sat;
  logic [7:0] rm_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_span <= SPAN_W'(10);
      delta_span <= SPAN_W'(6);
      output_step <= STEP_W'(6);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ERROR_SPAN: error_span <= cfg_data;
        REG_DELTA_SPAN: delta_span <= cfg_data;
        REG_OUTPUT_STEP: output_step <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[NST] = !result_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign sample_stall = !rdy[0];
  assign result_valid = v[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= sample_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      fz_e[0] <= fz_init(position_error, error_span);
      fz_d[0] <= fz_init(error_change, delta_span);
    end
  end

  for (genvar k = 1; k <= FZ_ST; k++) begin : g_fz
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        fz_e[k] <= fz_stage(fz_e[k-1], error_span);
        fz_d[k] <= fz_stage(fz_d[k-1], delta_span);
      end
    end
  end

  always_comb begin
    m_e = fz_e[FZ_ST].full ? MEM_ONE : (fz_e[FZ_ST].nil ? '0 : {1'b0, fz_e[FZ_ST].quo});
    m_d = fz_d[FZ_ST].full ? MEM_ONE : (fz_d[FZ_ST].nil ? '0 : {1'b0, fz_d[FZ_ST].quo});
    me[0] = fz_e[FZ_ST].neg ? m_e : '0;
    me[1] = MEM_ONE - m_e;
    me[2] = fz_e[FZ_ST].neg ? '0 : m_e;
    md[0] = fz_d[FZ_ST].neg ? m_d : '0;
    md[1] = MEM_ONE - m_d;
    md[2] = fz_d[FZ_ST].neg ? '0 : m_d;
  end

  // index 0 negative, 1 zero, 2 positive
  always_ff @(posedge clk) begin
    if (rdy[S_RULE]) begin
      rule_r[2] <= mmax(mmax(mmin(me[0], md[0]), mmin(me[0], md[1])), mmin(me[1], md[2]));
      rule_r[1] <= mmax(mmax(mmin(me[0], md[2]), mmin(me[1], md[1])), mmin(me[2], md[0]));
      rule_r[0] <= mmax(mmax(mmin(me[1], md[2]), mmin(me[2], md[1])), mmin(me[2], md[2]));
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_area
    always_ff @(posedge clk) begin
      if (rdy[S_Q]) begin
        q_r[j] <= rule_r[j];
        q_v[j] <= Q_W'(rule_r[j] * (MEM_ONE - rule_r[j]));
      end
      if (rdy[S_K]) begin
        k_r[j] <= q_r[j];
        k_v[j] <= KQ_W'(K_Q16 * q_v[j]) + KQ_W'(33'h080000000);
      end
      if (rdy[S_AREA]) begin
        if (j == 1) begin
          area[j] <= (AREA_W'(k_r[j]) << 2) + (AREA_W'(k_r[j]) << 1)
                     + AREA_W'(k_v[j][KQ_W-1:32]);
        end else begin
          area[j] <= (AREA_W'(k_r[j]) << 1) + AREA_W'(k_r[j])
                     + AREA_W'(k_v[j][KQ_W-1:32]);
        end
      end
    end
  end

  always_comb begin
    sn = $signed(COMB_W'(area[0]));
    sz = $signed(COMB_W'(area[1]));
    sp = $signed(COMB_W'(area[2]));
    if (area[1] >= AREA_W'(MEM_ONE)) begin
      cs_next = CASE_ZERO;
      den_next = area[1];
      comb = sp - sn;
    end else if (area[0] >= AREA_W'(MEM_ONE)) begin
      cs_next = CASE_NEG;
      den_next = area[0];
      comb = sz + (sp <<< 1) - sn;
    end else if (area[2] >= AREA_W'(MEM_ONE)) begin
      cs_next = CASE_POS;
      den_next = area[2];
      comb = sp - sz - (sn <<< 1);
    end else begin
      cs_next = CASE_UNKNOWN;
      den_next = AREA_W'(1);
      comb = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_SEL]) begin
      sel_cs <= cs_next;
      sel_den <= den_next;
      sel_neg <= comb[COMB_W-1];
      sel_mag <= CMAG_W'(comb[COMB_W-1] ? -comb : comb);
    end
    if (rdy[S_MUL]) begin
      mul_cs <= sel_cs;
      mul_den <= sel_den;
      mul_neg <= sel_neg;
      mul_p <= PROD_W'(sel_mag * output_step);
    end
    if (rdy[S_INIT]) begin
      od[0].neg <= mul_neg;
      od[0].cs <= mul_cs;
      od[0].den <= mul_den;
      od[0].ovf <= ({(AREA_W + QB)'(0), mul_p} >= ({(PROD_W + QB)'(0), mul_den} << OD_SH));
      od[0].rem <= AREA_W'(mul_p >> OD_SH);
      od[0].quo <= '0;
      od[0].nb <= QB'({mul_p, {(FRAC_BITS + 1){1'b0}}});
    end
  end

  for (genvar k = 1; k <= OD_ST; k++) begin : g_od
    always_ff @(posedge clk) begin
      if (rdy[S_INIT+k]) begin
        od[k] <= od_stage(od[k-1], (k - 1) * OD_PER);
      end
    end
  end

  always_comb begin
    fm = ({1'b0, od[OD_ST].quo} + (QB + 1)'(1)) >> 1;
    rm = QB'((od[OD_ST].quo >> 1) + QB'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    fm_cap = od[OD_ST].neg ? (QB + 1)'(32768) : (QB + 1)'(32767);
    rm_cap = od[OD_ST].neg ? QB'(128) : QB'(127);
    fm_sat = (od[OD_ST].ovf || fm > fm_cap) ? fm_cap[15:0] : fm[15:0];
    rm_sat = (od[OD_ST].ovf || rm > rm_cap) ? rm_cap[7:0] : rm[7:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      dominant_case <= od[OD_ST].cs;
      if (od[OD_ST].cs == CASE_UNKNOWN) begin
        angle_change_fine <= '0;
        angle_change_rounded <= '0;
      end else if (od[OD_ST].neg) begin
        angle_change_fine <= $signed(16'(~fm_sat + 16'd1));
        angle_change_rounded <= $signed(8'(~rm_sat + 8'd1));
      end else begin
        angle_change_fine <= $signed(fm_sat);
        angle_change_rounded <= $signed(rm_sat);
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/fuzzy_pd_angle_controller_core_tb.sv
// Self-checking testbench for the fuzzy PD angle controller core.
`timescale 1ns / 1ps
module fuzzy_pd_angle_controller_core_tb;
  import fpdac_pkg::*;

  typedef struct packed {
    logic signed [15:0] fine;
    logic signed [7:0] rnd;
    logic [1:0] cs;
  } angle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_ERROR_SPAN;
  logic [SPAN_W-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [15:0] position_error = '0;
  logic signed [15:0] error_change = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [15:0] angle_change_fine;
  logic signed [7:0] angle_change_rounded;
  logic [1:0] dominant_case;

  fuzzy_pd_angle_controller_core dut (.*);

  logic [6:0] err_span, dlt_span;
  logic [5:0] out_step;
  angle_t expected_angles[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic void fuzz(input logic [15:0] x, input logic [6:0] span,
                               output longint mn, output longint mz, output longint mp);
    longint mag, m;
    mag = x[15] ? 65536 - x : x;
    if (span == 0) m = (mag != 0) ? 65536 : 0;
    else begin
      m = (mag << 16) / (longint'(span) << FRAC_BITS);
      if (m > 65536) m = 65536;
    end
    mz = 65536 - m;
    mn = x[15] ? m : 0;
    mp = x[15] ? 0 : m;
  endfunction

  function automatic longint mn2(input longint a, input longint b);
    return a < b ? a : b;
  endfunction
  function automatic longint mx3(input longint a, input longint b, input longint c);
    longint m;
    m = a > b ? a : b;
    return m > c ? m : c;
  endfunction

  function automatic longint area(input longint r, input longint base);
    logic [63:0] t;
    t = (64'd193858 * (r * (65536 - r)) + 64'h8000_0000) >> 32;
    return base * r + longint'(t);
  endfunction

  function automatic angle_t predict_angle(input logic [15:0] pe, input logic [15:0] ec);
    longint en, ez, ep, dn, dz, dp, rp, rz, rn, ap, az, an, den, comb, mag, fm, rm;
    angle_t a;
    bit neg;
    fuzz(pe, err_span, en, ez, ep);
    fuzz(ec, dlt_span, dn, dz, dp);
    rp = mx3(mn2(en, dn), mn2(en, dz), mn2(ez, dp));
    rz = mx3(mn2(en, dp), mn2(ez, dz), mn2(ep, dn));
    rn = mx3(mn2(ez, dp), mn2(ep, dz), mn2(ep, dp));
    ap = area(rp, 3); az = area(rz, 6); an = area(rn, 3);
    if (az >= 65536) begin
      a.cs = CASE_ZERO; den = az; comb = ap - an;
    end else if (an >= 65536) begin
      a.cs = CASE_NEG; den = an; comb = az + 2 * ap - an;
    end else if (ap >= 65536) begin
      a.cs = CASE_POS; den = ap; comb = ap - az - 2 * an;
    end else begin
      a.cs = CASE_UNKNOWN; a.fine = '0; a.rnd = '0;
      return a;
    end
    neg = comb < 0;
    mag = (neg ? -comb : comb) * out_step;
    fm = ((mag << (FRAC_BITS + 1)) + den) / (2 * den);
    rm = ((mag << 1) + den) / (2 * den);
    if (fm > (neg ? 32768 : 32767)) fm = neg ? 32768 : 32767;
    if (rm > (neg ? 128 : 127)) rm = neg ? 128 : 127;
    a.fine = neg ? 16'(-fm) : 16'(fm);
    a.rnd = neg ? 8'(-rm) : 8'(rm);
    return a;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst) result_stall <= calm ? 1'b0 : ($urandom_range(99) < 6);
    if (!rst && result_valid && !result_stall) begin
      if (expected_angles.size() == 0) report("result with none expected");
      else begin
        angle_t e;
        e = expected_angles.pop_front();
        if (angle_change_fine !== e.fine)
          report($sformatf("fine got %0d want %0d", angle_change_fine, e.fine));
        if (angle_change_rounded !== e.rnd)
          report($sformatf("rounded got %0d want %0d", angle_change_rounded, e.rnd));
        if (dominant_case !== e.cs)
          report($sformatf("case got %0d want %0d", dominant_case, e.cs));
      end
    end
  end

  task automatic send_word(input logic [15:0] pe, input logic [15:0] ec);
    while (!calm && $urandom_range(99) < 6) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    position_error <= pe;
    error_change <= ec;
    do @(posedge clk); while (sample_stall);
    expected_angles.push_back(predict_angle(pe, ec));
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_ERROR_SPAN: err_span = val;
      REG_DELTA_SPAN: dlt_span = val;
      REG_OUTPUT_STEP: out_step = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [6:0] es, input logic [6:0] ds, input logic [6:0] st);
    drain();
    write_reg(REG_ERROR_SPAN, es);
    write_reg(REG_DELTA_SPAN, ds);
    write_reg(REG_OUTPUT_STEP, st);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value(input logic [6:0] span);
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(2 * span * 256)) - span * 256);
      2: return 16'($signed($urandom_range(4096)) - 2048);
      default: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] v[8] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff,
                          16'h0a00, 16'hf600, 16'h0300};
    for (int i = 0; i < 8; i++) send_word(v[i], v[(i * 3 + 1) % 8]);
    send_word(16'h0000, 16'h0000);
    send_word(16'h0500, 16'hfd00);
    send_word(16'hfb00, 16'h0300);
    send_word(16'h0a00, 16'h0600);
    send_word(16'hf600, 16'hfa00);
  endtask

  task automatic test_spans_zero();
    set_config(7'd0, 7'd0, 7'd63);
    send_word(16'h0000, 16'h0000);
    send_word(16'h0001, 16'h0000);
    send_word(16'h0000, 16'hffff);
    send_word(16'h8000, 16'h7fff);
    send_word(16'hffff, 16'hffff);
    set_config(7'd127, 7'd127, 7'd0);
    send_word(16'h7fff, 16'h8000);
    send_word(16'h4000, 16'h0000);
    send_word(16'h0000, 16'h0000);
  endtask

  task automatic test_random(input int n);
    logic [6:0] es, ds;
    for (int p = 0; p < 6; p++) begin
      es = (p == 0) ? 7'd1 : (p == 1) ? 7'd127 : 7'($urandom_range(1, 127));
      ds = (p == 0) ? 7'd127 : (p == 1) ? 7'd1 : 7'($urandom_range(1, 127));
      set_config(es, ds, (p == 0) ? 7'd1 : (p == 1) ? 7'd63 : 7'($urandom_range(127)));
      calm = (p == 3);
      for (int i = 0; i < n / 6; i++) send_word(pick_value(es), pick_value(ds));
    end
    calm = 1'b0;
  endtask

  initial begin
    err_span = 7'd10;
    dlt_span = 7'd6;
    out_step = 6'd6;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_spans_zero();
    test_random(930);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
